// File: rtl/ascii_motor_light_command_interpreter_defines.svh
// Shared assertion macros
`ifndef ASCII_MOTOR_LIGHT_COMMAND_INTERPRETER_DEFINES_SVH
`define ASCII_MOTOR_LIGHT_COMMAND_INTERPRETER_DEFINES_SVH

// same-cycle implication
`define AMLCI_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("amlci assertion failed");

// next-cycle implication
`define AMLCI_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("amlci assertion failed");

`endif

// File: rtl/amlci_pkg.sv
package amlci_pkg;

    localparam int KW_NUM = 5;

    localparam int KW_LIGHT  = 0;
    localparam int KW_MOTOR  = 1;
    localparam int KW_CLEAR  = 2;
    localparam int KW_COMMIT = 3;
    localparam int KW_INFO   = 4;

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_NUL   = 8'h00;

    localparam logic [2:0] POS_MAX  = 3'd7;
    localparam logic [2:0] IDX_SAT  = 3'd7;

    typedef logic [KW_NUM-1:0] kw_mask_t;

    localparam kw_mask_t KW_ALL = '1;

    localparam logic [7:0] KW_TEXT [KW_NUM][8] = '{
        '{8'h4C, 8'h49, 8'h47, 8'h48, 8'h54, 8'h00, 8'h00, 8'h00},
        '{8'h4D, 8'h4F, 8'h54, 8'h4F, 8'h52, 8'h00, 8'h00, 8'h00},
        '{8'h43, 8'h4C, 8'h45, 8'h41, 8'h52, 8'h00, 8'h00, 8'h00},
        '{8'h43, 8'h4F, 8'h4D, 8'h4D, 8'h49, 8'h54, 8'h00, 8'h00},
        '{8'h49, 8'h4E, 8'h46, 8'h4F, 8'h00, 8'h00, 8'h00, 8'h00}
    };

    localparam logic [2:0] KW_LEN [KW_NUM] = '{3'd5, 3'd5, 3'd5, 3'd6, 3'd4};

    typedef enum logic [1:0] {
        REPLY_SILENT  = 2'd0,
        REPLY_INFO    = 2'd1,
        REPLY_UNKNOWN = 2'd2
    } reply_t;

    typedef enum logic [1:0] {
        DRIVE_BRAKE   = 2'd0,
        DRIVE_FORWARD = 2'd1,
        DRIVE_REVERSE = 2'd2
    } drive_t;

    // finished line as handed from parser to executor
    typedef struct packed {
        kw_mask_t    cand;
        logic [2:0]  idx;
        logic [15:0] value;
        logic        empty;
        logic        has_args;
    } parse_res_t;

    typedef struct packed {
        logic   lamp_one;
        logic   lamp_zero;
        drive_t right_drive;
        drive_t left_drive;
        reply_t reply;
    } exec_out_t;

endpackage

// File: rtl/ascii_motor_light_command_interpreter.sv
// The last beat of a line is held in the input register; its result is written to the
// result register. Throughput: one input beat per cycle while no result waits on m_tready;
// while one waits, the input register can still take one beat if it is empty.
// Reset (aresetn low, synchronous): parser cleared, shadows zero, motors brake,
// lamps off, both channels empty.
module ascii_motor_light_command_interpreter #(
    parameter int MOTOR_COUNT = 2,
    parameter int LAMP_COUNT  = 2,
    parameter int TOKEN_LIMIT = 4
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] line_byte
    input  logic       s_tlast,   // line_end
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [1:0] reply, [3:2] left_drive, [5:4] right_drive,
                                  // [6] lamp_zero, [7] lamp_one
);
    import amlci_pkg::*;

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       m_tvalid_reg, m_tvalid_next;
    logic [7:0] m_tdata_reg;
    logic       advance;
    logic       fire;
    parse_res_t res;
    exec_out_t  eout;

    assign advance  = !m_tvalid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign fire     = in_valid_reg && advance;

    amlci_parser #(
        .TOKEN_LIMIT(TOKEN_LIMIT)
    ) u_parser (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (fire),
        .line_byte(in_byte_reg),
        .line_end (in_last_reg),
        .res      (res)
    );

    amlci_exec #(
        .MOTOR_COUNT(MOTOR_COUNT),
        .LAMP_COUNT (LAMP_COUNT)
    ) u_exec (
        .aclk   (aclk),
        .aresetn(aresetn),
        .fire   (fire && in_last_reg),
        .res    (res),
        .out    (eout)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end
        m_tvalid_next = m_tvalid_reg;
        if (fire && in_last_reg) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (fire && in_last_reg) begin
            m_tdata_reg <= {eout.lamp_one, eout.lamp_zero, eout.right_drive,
                            eout.left_drive, eout.reply};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// File: rtl/amlci_parser.sv
module amlci_parser #(
    parameter int TOKEN_LIMIT = 4
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step,
    input  logic [7:0]           line_byte,
    input  logic                 line_end,
    output amlci_pkg::parse_res_t res
);
    import amlci_pkg::*;

    localparam int CW = $clog2(TOKEN_LIMIT + 1);

    typedef struct packed {
        logic [CW-1:0] count;
        kw_mask_t      cand;
        logic [2:0]    pos;
        logic [2:0]    idx;
        logic [15:0]   value;
        logic          in_tok;
        logic          sign;
        logic          stopped;
    } pstate_t;

    localparam pstate_t PS_CLEAR = '{
        count: '0, cand: KW_ALL, pos: '0, idx: '0, value: '0,
        in_tok: 1'b0, sign: 1'b0, stopped: 1'b0
    };

    pstate_t work_reg, work_next;
    pstate_t kept_reg, kept_next;
    pstate_t w, kept_after, fin;
    logic    drop;
    logic    keep;

    function automatic pstate_t finish_tok(input pstate_t p);
        pstate_t q;
        q = p;
        if (p.in_tok && (p.count != '0)) begin
            if (p.count == CW'(1)) begin
                for (int k = 0; k < KW_NUM; k++) begin
                    if (KW_LEN[k] != p.pos) q.cand[k] = 1'b0;
                end
            end else if (p.count == CW'(2)) begin
                if (p.sign && (p.idx != '0)) q.idx = IDX_SAT;
            end else if (p.count == CW'(3)) begin
                if (p.sign) q.value = 16'(-p.value);
            end
            q.in_tok = 1'b0;
            q.sign   = 1'b0;
        end
        return q;
    endfunction

    function automatic pstate_t feed(input pstate_t p, input logic [7:0] c);
        pstate_t    q;
        logic [3:0] d;
        logic [6:0] iv;
        q  = p;
        d  = 4'(c - CHAR_ZERO);
        iv = 7'({p.idx, 3'b000}) + 7'({p.idx, 1'b0}) + 7'(d);
        if (p.count == CW'(1)) begin
            for (int k = 0; k < KW_NUM; k++) begin
                if ((p.pos >= KW_LEN[k]) || (KW_TEXT[k][p.pos] != c)) q.cand[k] = 1'b0;
            end
            if (p.pos != POS_MAX) q.pos = p.pos + 3'd1;
        end else if ((p.count == CW'(2)) || (p.count == CW'(3))) begin
            if (c == CHAR_PLUS) begin
                q.sign = 1'b0;
            end else if (c == CHAR_MINUS) begin
                q.sign = 1'b1;
            end else if ((c >= CHAR_ZERO) && (c <= CHAR_NINE)) begin
                if (p.count == CW'(2)) begin
                    q.idx = (iv > 7'(IDX_SAT)) ? IDX_SAT : iv[2:0];
                end else begin
                    q.value = {p.value[12:0], 3'b000} + {p.value[14:0], 1'b0} + 16'(d);
                end
            end
        end
        return q;
    endfunction

    always_comb begin
        w    = work_reg;
        drop = 1'b0;
        keep = 1'b0;
        if (!work_reg.stopped) begin
            if (line_byte == CHAR_NUL) begin
                w.stopped = 1'b1;
            end else if (line_byte == CHAR_SPACE) begin
                w = finish_tok(work_reg);
            end else begin
                if (!work_reg.in_tok) begin
                    if (work_reg.count >= CW'(TOKEN_LIMIT)) begin
                        drop = 1'b1;
                    end else begin
                        w.count  = work_reg.count + CW'(1);
                        w.in_tok = 1'b1;
                        w.sign   = 1'b0;
                    end
                end
                if (!drop) w = feed(w, line_byte);
            end
            keep = !drop && (line_byte > CHAR_SPACE);
        end
        kept_after = keep ? w : kept_reg;
        fin        = finish_tok(kept_after);
    end

    always_comb begin
        work_next = work_reg;
        kept_next = kept_reg;
        if (step) begin
            if (line_end) begin
                work_next = PS_CLEAR;
                kept_next = PS_CLEAR;
            end else begin
                work_next = w;
                kept_next = kept_after;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            work_reg <= PS_CLEAR;
            kept_reg <= PS_CLEAR;
        end else begin
            work_reg <= work_next;
            kept_reg <= kept_next;
        end
    end

    assign res.cand     = fin.cand;
    assign res.idx      = fin.idx;
    assign res.value    = fin.value;
    assign res.empty    = (fin.count == '0);
    assign res.has_args = (fin.count > CW'(2));

endmodule

// File: rtl/amlci_exec.sv
module amlci_exec #(
    parameter int MOTOR_COUNT = 2,
    parameter int LAMP_COUNT  = 2
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  fire,
    input  amlci_pkg::parse_res_t res,
    output amlci_pkg::exec_out_t  out
);
    import amlci_pkg::*;

    logic [15:0] shadow_lamp_reg  [LAMP_COUNT];
    logic [15:0] shadow_motor_reg [MOTOR_COUNT];
    logic        active_lamp_reg  [LAMP_COUNT];
    drive_t      active_drive_reg [MOTOR_COUNT];
    logic        active_lamp_next [LAMP_COUNT];
    drive_t      active_drive_next[MOTOR_COUNT];

    logic   do_light, do_motor, do_clear, do_commit;
    reply_t reply;
    logic [1:0] lamp_vec;
    drive_t     drive_vec [2];

    always_comb begin
        do_light  = 1'b0;
        do_motor  = 1'b0;
        do_clear  = 1'b0;
        do_commit = 1'b0;
        reply     = REPLY_SILENT;
        priority if (res.empty) begin
            reply = REPLY_SILENT;
        end else if (res.cand[KW_LIGHT]) begin
            do_light = res.has_args;
        end else if (res.cand[KW_MOTOR]) begin
            do_motor = res.has_args;
        end else if (res.cand[KW_CLEAR]) begin
            do_clear = 1'b1;
        end else if (res.cand[KW_COMMIT]) begin
            do_commit = 1'b1;
        end else if (res.cand[KW_INFO]) begin
            reply = REPLY_INFO;
        end else begin
            reply = REPLY_UNKNOWN;
        end
    end

    always_comb begin
        for (int i = 0; i < LAMP_COUNT; i++) begin
            active_lamp_next[i] = do_commit ? (shadow_lamp_reg[i][7:0] != 8'h00)
                                            : active_lamp_reg[i];
        end
        for (int i = 0; i < MOTOR_COUNT; i++) begin
            if (!do_commit) begin
                active_drive_next[i] = active_drive_reg[i];
            end else if (shadow_motor_reg[i] == 16'h0000) begin
                active_drive_next[i] = DRIVE_BRAKE;
            end else if (shadow_motor_reg[i][15]) begin
                active_drive_next[i] = DRIVE_REVERSE;
            end else begin
                active_drive_next[i] = DRIVE_FORWARD;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < LAMP_COUNT; i++) begin
                shadow_lamp_reg[i] <= '0;
                active_lamp_reg[i] <= 1'b0;
            end
            for (int i = 0; i < MOTOR_COUNT; i++) begin
                shadow_motor_reg[i] <= '0;
                active_drive_reg[i] <= DRIVE_BRAKE;
            end
        end else if (fire) begin
            for (int i = 0; i < LAMP_COUNT; i++) begin
                if (do_clear) begin
                    shadow_lamp_reg[i] <= '0;
                end else if (do_light && (res.idx == 3'(i))) begin
                    shadow_lamp_reg[i] <= res.value;
                end
                active_lamp_reg[i] <= active_lamp_next[i];
            end
            for (int i = 0; i < MOTOR_COUNT; i++) begin
                if (do_clear) begin
                    shadow_motor_reg[i] <= '0;
                end else if (do_motor && (res.idx == 3'(i))) begin
                    shadow_motor_reg[i] <= res.value;
                end
                active_drive_reg[i] <= active_drive_next[i];
            end
        end
    end

    for (genvar g = 0; g < 2; g++) begin : g_pins
        if (g < LAMP_COUNT) begin : g_lamp
            assign lamp_vec[g] = active_lamp_next[g];
        end else begin : g_no_lamp
            assign lamp_vec[g] = 1'b0;
        end
        if (g < MOTOR_COUNT) begin : g_motor
            assign drive_vec[g] = active_drive_next[g];
        end else begin : g_no_motor
            assign drive_vec[g] = DRIVE_BRAKE;
        end
    end

    assign out.reply       = reply;
    assign out.left_drive  = drive_vec[0];
    assign out.right_drive = drive_vec[1];
    assign out.lamp_zero   = lamp_vec[0];
    assign out.lamp_one    = lamp_vec[1];

endmodule

// File: rtl/amlci_checker.sv
`include "ascii_motor_light_command_interpreter_defines.svh"

module amlci_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [7:0] s_tdata,
    input logic       s_tlast,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);
    import amlci_pkg::*;

    logic in_beat;
    assign in_beat = s_tvalid && s_tready && (s_tdata != 8'h00 || !s_tlast);

    // a held result beat keeps its payload
    `AMLCI_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata))

    // input only stalls behind a waiting result
    `AMLCI_ASSERT_NOW(a_stall_cause, aclk, aresetn, !s_tready, m_tvalid)

    // reply code is always a legal one
    `AMLCI_ASSERT_NOW(a_reply_code, aclk, aresetn, m_tvalid,
        m_tdata[1:0] == REPLY_SILENT || m_tdata[1:0] == REPLY_INFO ||
        m_tdata[1:0] == REPLY_UNKNOWN)

    // drive codes are always legal
    `AMLCI_ASSERT_NOW(a_drive_code, aclk, aresetn, m_tvalid,
        m_tdata[3:2] != 2'b11 && m_tdata[5:4] != 2'b11)

    // a non-final beat with no final beat in flight raises no result next cycle
    `AMLCI_ASSERT_NEXT(a_no_early_result, aclk, aresetn,
        in_beat && !s_tlast && !m_tvalid && s_tready &&
        $past(!(s_tvalid && s_tready && s_tlast)) && $past(!m_tvalid), !m_tvalid)

endmodule

bind ascii_motor_light_command_interpreter amlci_checker u_amlci_checker (.*);

// File: tb/amlci_status_checker.sv
`timescale 1ns / 1ps

module amlci_status_checker #(
    parameter int MOTOR_COUNT = 2,
    parameter int LAMP_COUNT  = 2,
    parameter int TOKEN_LIMIT = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,
    output int unsigned fail_count,
    output int unsigned pending,
    output int unsigned compared
);
    import amlci_pkg::*;

    typedef struct {
        int unsigned ntok;
        kw_mask_t    cand;
        logic [2:0]  kpos;
        logic [2:0]  idx;
        logic [15:0] val;
        logic        in_tok;
        logic        neg;
        logic        pend;
        logic        stopped;
    } scan_t;

    typedef struct {
        reply_t reply;
        drive_t left;
        drive_t right;
        logic   lamp0;
        logic   lamp1;
    } status_t;

    string       kw_word [KW_NUM];
    scan_t       work_scan;
    scan_t       kept_scan;
    logic [15:0] sh_lamp [2];
    logic [15:0] sh_motor [2];
    logic        act_lamp [2];
    drive_t      act_drive [2];
    status_t     status_q [$];

    initial begin
        kw_word[KW_LIGHT]  = "LIGHT";
        kw_word[KW_MOTOR]  = "MOTOR";
        kw_word[KW_CLEAR]  = "CLEAR";
        kw_word[KW_COMMIT] = "COMMIT";
        kw_word[KW_INFO]   = "INFO";
    end

    function automatic scan_t scan_idle();
        scan_t s;
        s.ntok    = 0;
        s.cand    = KW_ALL;
        s.kpos    = '0;
        s.idx     = '0;
        s.val     = '0;
        s.in_tok  = 1'b0;
        s.neg     = 1'b0;
        s.pend    = 1'b0;
        s.stopped = 1'b0;
        return s;
    endfunction

    function automatic scan_t scan_close(scan_t s);
        if (!s.in_tok || s.ntok == 0) return s;
        if (s.ntok == 1) begin
            for (int k = 0; k < KW_NUM; k++)
                if (kw_word[k].len() != int'(s.kpos)) s.cand[k] = 1'b0;
        end else if (s.ntok == 2) begin
            if (s.neg && s.idx != 3'd0) s.idx = IDX_SAT;
        end else if (s.ntok == 3) begin
            if (s.neg) s.val = 16'd0 - s.val;
        end
        s.in_tok = 1'b0;
        s.neg    = 1'b0;
        return s;
    endfunction

    function automatic scan_t scan_feed(scan_t s, logic [7:0] c);
        int unsigned v;
        if (s.ntok == 1) begin
            for (int k = 0; k < KW_NUM; k++)
                if (int'(s.kpos) >= kw_word[k].len() || 8'(kw_word[k][s.kpos]) != c)
                    s.cand[k] = 1'b0;
            if (s.kpos < POS_MAX) s.kpos = s.kpos + 3'd1;
        end else if (s.ntok == 2 || s.ntok == 3) begin
            if (c == CHAR_PLUS) begin
                s.neg = 1'b0;
            end else if (c == CHAR_MINUS) begin
                s.neg = 1'b1;
            end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
                if (s.ntok == 2) begin
                    v = int'(s.idx) * 10 + int'(c - CHAR_ZERO);
                    s.idx = (v > int'(IDX_SAT)) ? IDX_SAT : v[2:0];
                end else begin
                    s.val = 16'(int'(s.val) * 10 + int'(c - CHAR_ZERO));
                end
            end
        end
        return s;
    endfunction

    task automatic scan_byte(input logic [7:0] b);
        if (work_scan.stopped) return;
        if (b == CHAR_NUL) begin
            work_scan.stopped = 1'b1;
            return;
        end
        if (b == CHAR_SPACE) begin
            work_scan = scan_close(work_scan);
        end else begin
            if (!work_scan.in_tok) begin
                if (work_scan.ntok >= TOKEN_LIMIT) return;
                work_scan.ntok++;
                work_scan.in_tok = 1'b1;
                work_scan.neg    = 1'b0;
            end
            work_scan = scan_feed(work_scan, b);
        end
        // trailing bytes of 32 or less only count once something visible follows
        if (b > CHAR_SPACE) begin
            work_scan.pend = 1'b0;
            kept_scan = work_scan;
        end else begin
            work_scan.pend = 1'b1;
        end
    endtask

    task automatic run_line(output reply_t r);
        scan_t p;
        p = scan_close(kept_scan);
        r = REPLY_SILENT;
        if (p.ntok == 0) return;
        if (p.cand[KW_LIGHT]) begin
            if (p.ntok > 2 && p.idx <= 3'd1 && int'(p.idx) < LAMP_COUNT)
                sh_lamp[p.idx[0]] = p.val;
        end else if (p.cand[KW_MOTOR]) begin
            if (p.ntok > 2 && p.idx <= 3'd1 && int'(p.idx) < MOTOR_COUNT)
                sh_motor[p.idx[0]] = p.val;
        end else if (p.cand[KW_CLEAR]) begin
            for (int i = 0; i < 2; i++) begin
                sh_lamp[i]  = '0;
                sh_motor[i] = '0;
            end
        end else if (p.cand[KW_COMMIT]) begin
            for (int i = 0; i < 2; i++) begin
                if (i < LAMP_COUNT) act_lamp[i] = |sh_lamp[i][7:0];
                if (i < MOTOR_COUNT)
                    act_drive[i] = (sh_motor[i] == 16'd0) ? DRIVE_BRAKE :
                                   sh_motor[i][15] ? DRIVE_REVERSE : DRIVE_FORWARD;
            end
        end else if (p.cand[KW_INFO]) begin
            r = REPLY_INFO;
        end else begin
            r = REPLY_UNKNOWN;
        end
    endtask

    always @(posedge aclk) begin
        status_t want;
        reply_t  r;
        if (!aresetn) begin
            work_scan = scan_idle();
            kept_scan = scan_idle();
            for (int i = 0; i < 2; i++) begin
                sh_lamp[i]   = '0;
                sh_motor[i]  = '0;
                act_lamp[i]  = 1'b0;
                act_drive[i] = DRIVE_BRAKE;
            end
            status_q.delete();
            fail_count = 0;
            compared   = 0;
            pending    = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (status_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: status beat %h with no line waiting", $time, m_tdata);
                end else begin
                    want = status_q.pop_front();
                    compared++;
                    if (want.reply !== m_tdata[1:0] || want.left !== m_tdata[3:2] ||
                        want.right !== m_tdata[5:4] || want.lamp0 !== m_tdata[6] ||
                        want.lamp1 !== m_tdata[7]) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"%0t: status beat %0d: expected reply %0d drive %0d/%0d ",
                                      "lamps %0b/%0b, got reply %0d drive %0d/%0d lamps %0b/%0b"},
                                     $time, compared, want.reply, want.left, want.right,
                                     want.lamp0, want.lamp1, m_tdata[1:0], m_tdata[3:2],
                                     m_tdata[5:4], m_tdata[6], m_tdata[7]);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                scan_byte(s_tdata);
                if (s_tlast) begin
                    run_line(r);
                    want.reply = r;
                    want.left  = act_drive[0];
                    want.right = act_drive[1];
                    want.lamp0 = act_lamp[0];
                    want.lamp1 = act_lamp[1];
                    status_q.push_back(want);
                    work_scan = scan_idle();
                    kept_scan = scan_idle();
                end
            end
            pending = status_q.size();
        end
    end

endmodule

// File: tb/ascii_motor_light_command_interpreter_tb.sv
`timescale 1ns / 1ps

module ascii_motor_light_command_interpreter_tb;
    import amlci_pkg::*;

    localparam int MOTOR_COUNT    = 2;
    localparam int LAMP_COUNT     = 2;
    localparam int TOKEN_LIMIT    = 4;
    localparam int ITEM_TARGET    = 1650;
    localparam int HOLD_AT        = 800;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 3000;

    logic       aclk;
    logic       aresetn;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       s_tlast;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;

    int unsigned fail_count;
    int unsigned pending;
    int unsigned compared;

    logic [7:0]  line_bytes [$];
    int unsigned lines_sent;
    int unsigned bytes_sent;
    int unsigned burst_left;
    int unsigned idle_cycles;
    int unsigned stall_mode;
    int unsigned mode_left;
    int unsigned ready_phase;
    int unsigned hold_count;
    logic        hold_req;
    logic        hold_done;

    string near_words [12] = '{"LIGH", "LIGHTS", "MOTO", "MOTORS", "CLEA", "CLEARX",
                               "COMMI", "COMMITTED", "INF", "INFORMATION", "light", "Info"};

    ascii_motor_light_command_interpreter #(
        .MOTOR_COUNT(MOTOR_COUNT),
        .LAMP_COUNT (LAMP_COUNT),
        .TOKEN_LIMIT(TOKEN_LIMIT)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    amlci_status_checker #(
        .MOTOR_COUNT(MOTOR_COUNT),
        .LAMP_COUNT (LAMP_COUNT),
        .TOKEN_LIMIT(TOKEN_LIMIT)
    ) status_chk (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .fail_count(fail_count),
        .pending   (pending),
        .compared  (compared)
    );

    initial aclk = 1'b0;
    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic put_str(input string t);
        for (int i = 0; i < t.len(); i++) line_bytes.push_back(8'(t[i]));
    endtask

    task automatic put_gap();
        repeat ($urandom_range(1, 3)) line_bytes.push_back(CHAR_SPACE);
    endtask

    task automatic put_index();
        case ($urandom_range(0, 15))
            0, 1, 2, 3, 4: put_str("0");
            5, 6, 7, 8, 9: put_str("1");
            10: put_str("-0");
            11: put_str("+1");
            12: put_str("01");
            13: put_str($sformatf("%0d", $urandom_range(2, 300)));
            14: put_str("-1");
            default: put_str("1z");
        endcase
    endtask

    task automatic put_value();
        int unsigned mag;
        case ($urandom_range(0, 5))
            0: put_str("+");
            1, 2: put_str("-");
            3: put_str($urandom_range(0, 1) ? "+-" : "-+");
            default: ;
        endcase
        case ($urandom_range(0, 7))
            0, 1, 2, 3: mag = $urandom_range(0, 300);
            4: mag = $urandom_range(0, 99999);
            5: mag = 0;
            6: begin
                case ($urandom_range(0, 5))
                    0: mag = 255;
                    1: mag = 256;
                    2: mag = 32767;
                    3: mag = 32768;
                    4: mag = 65535;
                    default: mag = 65536;
                endcase
            end
            default: mag = $urandom_range(0, 9);
        endcase
        put_str($sformatf("%0d", mag));
        if ($urandom_range(0, 7) == 0) begin
            line_bytes.push_back(8'(8'h41 + $urandom_range(0, 25)));
            line_bytes.push_back(8'(CHAR_ZERO + $urandom_range(0, 9)));
        end
        if ($urandom_range(0, 9) == 0) line_bytes.push_back(CHAR_MINUS);
    endtask

    task automatic build_line();
        int unsigned kind;
        line_bytes.delete();
        if ($urandom_range(0, 4) == 0) put_gap();
        kind = $urandom_range(0, 99);
        if (kind < 40) begin
            put_str($urandom_range(0, 1) ? "LIGHT" : "MOTOR");
            put_gap();
            put_index();
            put_gap();
            put_value();
        end else if (kind < 60) begin
            put_str("COMMIT");
        end else if (kind < 65) begin
            put_str("CLEAR");
        end else if (kind < 72) begin
            put_str("INFO");
        end else if (kind < 80) begin
            put_str(near_words[$urandom_range(0, 11)]);
        end else if (kind < 86) begin
            put_str($urandom_range(0, 1) ? "LIGHT" : "MOTOR");
            if ($urandom_range(0, 1)) begin
                put_gap();
                put_index();
            end
        end else if (kind < 92) begin
            repeat ($urandom_range(1, 12)) line_bytes.push_back(8'($urandom_range(0, 255)));
        end else if (kind < 96) begin
            repeat ($urandom_range(1, 3)) line_bytes.push_back(8'($urandom_range(0, 32)));
        end else begin
            put_str($urandom_range(0, 1) ? "LIGHT" : "MOTOR");
            put_gap();
            put_index();
            put_gap();
            put_value();
            repeat ($urandom_range(1, 3)) begin
                put_gap();
                put_value();
            end
        end
        // control byte that stays part of the token
        if ($urandom_range(0, 9) == 0) begin
            line_bytes.push_back(8'($urandom_range(1, 31)));
            line_bytes.push_back(8'h21);
        end
        if ($urandom_range(0, 9) == 0)
            line_bytes.insert($urandom_range(0, line_bytes.size() - 1), CHAR_NUL);
        if ($urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, 2)) line_bytes.push_back(8'($urandom_range(0, 32)));
    endtask

    task automatic send_beat(input logic [7:0] b, input logic last);
        int unsigned gap;
        if (burst_left == 0) begin
            if ($urandom_range(0, 5) == 0) begin
                burst_left = $urandom_range(60, 200);
                gap = 0;
            end else begin
                burst_left = $urandom_range(1, 24);
                gap = $urandom_range(0, 10);
            end
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        burst_left--;
        bytes_sent++;
    endtask

    task automatic send_line();
        for (int i = 0; i < line_bytes.size(); i++)
            send_beat(line_bytes[i], i == line_bytes.size() - 1);
        lines_sent++;
    endtask

    initial begin
        m_tready    = 1'b0;
        mode_left   = 0;
        ready_phase = 0;
        hold_done   = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req && !hold_done) begin
                m_tready <= 1'b0;
                hold_count = 0;
                while (hold_count < HOLD_CYCLES) begin
                    @(negedge aclk);
                    hold_count++;
                end
                hold_done = 1'b1;
                m_tready <= 1'b1;
            end else begin
                if (mode_left == 0) begin
                    stall_mode = $urandom_range(0, 3);
                    mode_left  = $urandom_range(16, 160);
                end
                mode_left--;
                ready_phase++;
                case (stall_mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 3) != 0);
                    2: m_tready <= ($urandom_range(0, 1) != 0);
                    default: m_tready <= ((ready_phase % 6) < 2);
                endcase
            end
        end
    end

    initial begin
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = 8'h00;
        s_tlast    = 1'b0;
        hold_req   = 1'b0;
        lines_sent = 0;
        bytes_sent = 0;
        burst_left = 0;
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;

        line_bytes.delete();
        line_bytes.push_back(8'hFF);
        send_line();
        line_bytes.delete();
        line_bytes.push_back(CHAR_NUL);
        send_line();
        line_bytes.delete();
        put_str("INFO");
        send_line();
        line_bytes.delete();
        put_str("MOTOR -0 -1");
        send_line();
        line_bytes.delete();
        put_str("COMMIT");
        send_line();

        while (bytes_sent < ITEM_TARGET) begin
            if (bytes_sent >= HOLD_AT && !hold_req) hold_req <= 1'b1;
            build_line();
            send_line();
        end
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;

        while (pending != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);

        $display("Covered %0d command lines in %0d bytes, %0d status beats compared,",
                 lines_sent, bytes_sent, compared);
        $display("with bursty input, varied output stalls and one %0d-cycle output hold-off.",
                 HOLD_CYCLES);
        if (fail_count == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// File: ascii_motor_light_command_interpreter.f
+incdir+rtl
rtl/amlci_pkg.sv
rtl/amlci_parser.sv
rtl/amlci_exec.sv
rtl/ascii_motor_light_command_interpreter.sv
rtl/amlci_checker.sv
tb/amlci_status_checker.sv
tb/ascii_motor_light_command_interpreter_tb.sv
